// ===== rtl/rfm_pkg.sv =====
package rfm_pkg;

   // Fixed widths of the data fields
   localparam int DATA_W = 32;
   localparam int STEP_W = $clog2(DATA_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

   // Tick counter: width follows COUNT_WIDTH, capped at the period field width
   localparam int COUNT_WIDTH = 32;
   localparam int CNT_W = (COUNT_WIDTH > DATA_W) ? DATA_W : COUNT_WIDTH;
   localparam logic [CNT_W-1:0] CNT_LIMIT = '1;

   localparam logic [DATA_W-1:0] REF_HZ_RESET = 32'd8000000;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // Falling-edge event from the counter
   typedef struct packed {
      logic              fire;
      logic [DATA_W-1:0] period;
      logic              sat;
   } edge_evt_type;

   typedef struct packed {
      logic ready;
      logic valid;
   } div_status_type;

endpackage

// ===== rtl/rfm_counter.sv =====
module rfm_counter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick,
   input  logic                  level,
   output rfm_pkg::edge_evt_type evt
);
   import rfm_pkg::*;

   logic             prev_ff, prev_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sat_ff, sat_in;
   logic [CNT_W-1:0] count_inc;
   logic             sat_next;
   logic             fire;

   always_comb begin
      count_inc = (count_ff < CNT_LIMIT) ? count_ff + 1'b1 : count_ff;
      sat_next  = sat_ff | (count_inc == CNT_LIMIT);
      fire      = prev_ff & ~level;

      prev_in  = prev_ff;
      count_in = count_ff;
      sat_in   = sat_ff;
      if (tick) begin
         prev_in = level;
         if (fire) begin
            count_in = '0;
            sat_in   = 1'b0;
         end else begin
            count_in = count_inc;
            sat_in   = sat_next;
         end
      end

      evt.fire   = fire;
      evt.period = DATA_W'(count_inc);
      evt.sat    = sat_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         count_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         count_ff <= count_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// ===== rtl/rfm_divider.sv =====
module rfm_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rfm_pkg::DATA_W-1:0]    dividend,
   input  logic [rfm_pkg::DATA_W-1:0]    divisor,
   input  logic                          ack,
   output rfm_pkg::div_status_type       status,
   output logic [rfm_pkg::DATA_W-1:0]    quotient
);
   import rfm_pkg::*;

   div_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] dvd_ff, dvd_in;   // dividend shifts out, quotient shifts in
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [DATA_W:0]   diff;
   logic              qbit;

   // One restoring step per cycle
   always_comb begin
      diff = {rem_ff, dvd_ff[DATA_W-1]} - {1'b0, dsr_ff};
      qbit = ~diff[DATA_W];
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               dvd_in   = dividend;
               dsr_in   = divisor;
               rem_in   = '0;
               step_in  = '0;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            dvd_in  = {dvd_ff[DATA_W-2:0], qbit};
            rem_in  = qbit ? diff[DATA_W-1:0] : {rem_ff[DATA_W-2:0], dvd_ff[DATA_W-1]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (ack) begin
               state_in = DIV_IDLE;
            end
         end
         default: state_in = DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign status.ready = (state_ff == DIV_IDLE);
   assign status.valid = (state_ff == DIV_DONE);
   assign quotient     = dvd_ff;

endmodule

// ===== rtl/reciprocal_frequency_meter.sv =====
// Reciprocal frequency meter: one sample transfer per reference tick.
// Non-edge samples are taken every cycle while the divider is idle. A falling edge
// starts a bit-serial divider (one quotient bit per cycle); input stalls from the
// edge transfer until the quotient is loaded into the output register, which waits
// while an earlier result is still held there. rsp_tvalid rises after that load.
// Synchronous active-high reset clears counter, edge state and result valid,
// and loads reference_hz with 8000000.
module reciprocal_frequency_meter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] signal_level
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [2*rfm_pkg::DATA_W-1:0]   rsp_tdata,   // {frequency_value, period_ticks}
   output logic                           rsp_tuser,   // period_saturated
   input  logic                           csr_wen,
   input  logic [rfm_pkg::DATA_W-1:0]     csr_wdata
);
   import rfm_pkg::*;

   logic [DATA_W-1:0] ref_hz_ff;
   logic [DATA_W-1:0] pend_period_ff;
   logic              pend_sat_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_period_ff;
   logic [DATA_W-1:0] rsp_freq_ff;
   logic              rsp_sat_ff;

   edge_evt_type      evt;
   div_status_type    div_stat;
   logic [DATA_W-1:0] quotient;
   logic              req_xfer;
   logic              start;
   logic              load_out;

   assign req_tready = div_stat.ready;
   assign req_xfer   = req_tvalid & req_tready;
   assign start      = req_xfer & evt.fire;
   assign load_out   = div_stat.valid & (~rsp_valid_ff | rsp_tready);

   rfm_counter u_counter (
      .clock (clock),
      .reset (reset),
      .tick  (req_xfer),
      .level (req_tdata[0]),
      .evt   (evt)
   );

   rfm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .dividend (ref_hz_ff),
      .divisor  (evt.period),
      .ack      (load_out),
      .status   (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_hz_ff    <= REF_HZ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            ref_hz_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pend_period_ff <= evt.period;
         pend_sat_ff    <= evt.sat;
      end
      if (load_out) begin
         rsp_period_ff <= pend_period_ff;
         rsp_freq_ff   <= quotient;
         rsp_sat_ff    <= pend_sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_freq_ff, rsp_period_ff};
   assign rsp_tuser  = rsp_sat_ff;

`ifndef SYNTH
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_period_ff != '0))
      else $error("result period is zero");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |-> (rsp_period_ff == DATA_W'(CNT_LIMIT)))
      else $error("saturated result below counter limit");

   a_stall_on_edge: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("input not held while dividing");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");
`endif

endmodule
